### rtl/jpp_pkg.sv
// shared types, character codes and microcode definitions for the json pretty printer
`default_nettype none

package jpp_pkg;

	// character codes
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	// microcode address
	localparam int UA_W = 4;
	typedef logic [UA_W-1:0] uaddr_t;

	// microcode program addresses
	localparam uaddr_t UA_PASS       = 4'd0;
	localparam uaddr_t UA_DROP       = 4'd1;
	localparam uaddr_t UA_COLON      = 4'd2;
	localparam uaddr_t UA_COLON_SP   = 4'd3;
	localparam uaddr_t UA_OPEN       = 4'd4;
	localparam uaddr_t UA_COMMA      = 4'd5;
	localparam uaddr_t UA_NL_LOAD    = 4'd6;
	localparam uaddr_t UA_INDENT     = 4'd7;
	localparam uaddr_t UA_CLOSE      = 4'd8;
	localparam uaddr_t UA_CLOSE_LOAD = 4'd9;
	localparam uaddr_t UA_CLOSE_IND  = 4'd10;
	localparam uaddr_t UA_CLOSE_BYTE = 4'd11;

	// what a microword sends to the output
	typedef enum logic [1:0] {
		EM_NONE = 2'd0,
		EM_BYTE = 2'd1,
		EM_NL   = 2'd2,
		EM_SP   = 2'd3
	} emit_t;

	// how the run_last flag of the emitted item is chosen
	typedef enum logic [1:0] {
		LS_NO     = 2'd0,
		LS_YES    = 2'd1,
		LS_DEPTH0 = 2'd2,
		LS_CNT1   = 2'd3
	} last_t;

	// nesting depth update
	typedef enum logic [1:0] {
		DP_HOLD = 2'd0,
		DP_INC  = 2'd1,
		DP_DEC  = 2'd2
	} dep_t;

	// indent counter update
	typedef enum logic [1:0] {
		CN_HOLD = 2'd0,
		CN_LOAD = 2'd1,
		CN_DEC  = 2'd2
	} cnt_t;

	// one control word
	typedef struct packed {
		emit_t  emit;
		last_t  lst;
		dep_t   dep;
		cnt_t   cnt;
		logic   rpt;    // repeat while more than one space is left
		logic   zskip;  // skip the word when the counter is zero
		logic   fin;    // item is finished when this word is left
		uaddr_t nxt;
	} ctrl_t;

	// sequencer to datapath
	typedef struct packed {
		logic accept;
		logic act;
		logic done;
	} exec_t;

	// datapath to sequencer
	typedef struct packed {
		logic cnt_zero;
		logic cnt_one;
		logic out_free;
	} stat_t;

endpackage

`default_nettype wire

### rtl/jpp_ucode_rom.sv
// microcode program store of the json pretty printer
`default_nettype none

module jpp_ucode_rom (
	input  wire jpp_pkg::uaddr_t addr,
	output jpp_pkg::ctrl_t       word
);
	import jpp_pkg::*;

	// program table
	always_comb begin
		word = '{emit: EM_NONE, lst: LS_NO, dep: DP_HOLD, cnt: CN_HOLD,
			rpt: 1'b0, zskip: 1'b0, fin: 1'b1, nxt: UA_PASS};
		case (addr)
			UA_PASS: begin
				word.emit = EM_BYTE;
				word.lst  = LS_YES;
			end
			UA_DROP: begin
				word.emit = EM_NONE;
			end
			UA_COLON: begin
				word.emit = EM_BYTE;
				word.fin  = 1'b0;
				word.nxt  = UA_COLON_SP;
			end
			UA_COLON_SP: begin
				word.emit = EM_SP;
				word.lst  = LS_YES;
			end
			UA_OPEN: begin
				word.emit = EM_BYTE;
				word.dep  = DP_INC;
				word.fin  = 1'b0;
				word.nxt  = UA_NL_LOAD;
			end
			UA_COMMA: begin
				word.emit = EM_BYTE;
				word.fin  = 1'b0;
				word.nxt  = UA_NL_LOAD;
			end
			UA_NL_LOAD: begin
				word.emit = EM_NL;
				word.lst  = LS_DEPTH0;
				word.cnt  = CN_LOAD;
				word.fin  = 1'b0;
				word.nxt  = UA_INDENT;
			end
			UA_INDENT: begin
				word.emit  = EM_SP;
				word.lst   = LS_CNT1;
				word.cnt   = CN_DEC;
				word.rpt   = 1'b1;
				word.zskip = 1'b1;
			end
			UA_CLOSE: begin
				word.emit = EM_NL;
				word.dep  = DP_DEC;
				word.fin  = 1'b0;
				word.nxt  = UA_CLOSE_LOAD;
			end
			UA_CLOSE_LOAD: begin
				word.cnt = CN_LOAD;
				word.fin = 1'b0;
				word.nxt = UA_CLOSE_IND;
			end
			UA_CLOSE_IND: begin
				word.emit  = EM_SP;
				word.cnt   = CN_DEC;
				word.rpt   = 1'b1;
				word.zskip = 1'b1;
				word.fin   = 1'b0;
				word.nxt   = UA_CLOSE_BYTE;
			end
			UA_CLOSE_BYTE: begin
				word.emit = EM_BYTE;
				word.lst  = LS_YES;
			end
			default: begin
				word.emit = EM_NONE;
			end
		endcase
	end

endmodule

`default_nettype wire

### rtl/jpp_seq.sv
// step counter and dispatch of the json pretty printer
`default_nettype none

module jpp_seq (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  s_tvalid,
	output logic                 s_tready,
	input  wire jpp_pkg::uaddr_t entry,
	input  wire jpp_pkg::ctrl_t  ctrl,
	input  wire jpp_pkg::stat_t  st,
	output jpp_pkg::uaddr_t      step,
	output jpp_pkg::exec_t       ex
);
	import jpp_pkg::*;

	logic   busy_q;
	uaddr_t step_q;
	logic   skip;
	logic   stall;
	logic   run;
	logic   stay;

	// word execution control
	always_comb begin
		skip     = ctrl.zskip && st.cnt_zero;
		stall    = !skip && (ctrl.emit != EM_NONE) && !st.out_free;
		run      = busy_q && !stall;
		stay     = ctrl.rpt && !st.cnt_zero && !st.cnt_one;
		s_tready = !busy_q;
		ex.accept = s_tvalid && !busy_q;
		ex.act    = run && !skip;
		ex.done   = run && !stay && ctrl.fin;
	end

	assign step = step_q;

	// step counter with dispatch and conditional repeat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= UA_PASS;
		end else if (ex.accept) begin
			busy_q <= 1'b1;
			step_q <= entry;
		end else if (run && !stay) begin
			if (ctrl.fin) begin
				busy_q <= 1'b0;
			end else begin
				step_q <= ctrl.nxt;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/jpp_dpath.sv
// datapath of the json pretty printer: scan state, depth, indent counter, output register
`default_nettype none

module jpp_dpath #(
	parameter int MAX_DEPTH        = 15,
	parameter int SPACES_PER_LEVEL = 2
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire [7:0]           s_tdata,
	input  wire                 s_tlast,
	input  wire                 cfg_we,
	input  wire                 cfg_wdata,
	input  wire jpp_pkg::ctrl_t ctrl,
	input  wire jpp_pkg::exec_t ex,
	output jpp_pkg::uaddr_t     entry,
	output jpp_pkg::stat_t      st,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [7:0]          m_tdata,
	output logic                m_tlast
);
	import jpp_pkg::*;

	localparam int DW = $clog2(MAX_DEPTH + 1);
	localparam int CW = $clog2(MAX_DEPTH * SPACES_PER_LEVEL + 1);

	logic          pretty_q;
	logic          str_q;
	logic          bsl_q;
	logic [DW-1:0] depth_q;
	logic [CW-1:0] cnt_q;
	logic [7:0]    byte_q;
	logic          eot_q;
	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic          str_nx;
	logic          ld;
	logic [7:0]    emit_byte;
	logic          emit_last;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pretty_q <= 1'b1;
		end else if (cfg_we) begin
			pretty_q <= cfg_wdata;
		end
	end

	// classify the incoming byte into a program entry
	always_comb begin
		str_nx = str_q;
		if (s_tdata == CH_QUOTE && !bsl_q) begin
			str_nx = !str_q;
		end
		if (!pretty_q || str_nx) begin
			entry = UA_PASS;
		end else if (s_tdata inside {CH_LBRACE, CH_LBRACK}) begin
			entry = UA_OPEN;
		end else if (s_tdata inside {CH_RBRACE, CH_RBRACK}) begin
			entry = UA_CLOSE;
		end else if (s_tdata == CH_COMMA) begin
			entry = UA_COMMA;
		end else if (s_tdata == CH_COLON) begin
			entry = UA_COLON;
		end else if (s_tdata inside {CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR}) begin
			entry = UA_DROP;
		end else begin
			entry = UA_PASS;
		end
	end

	// captured item
	always_ff @(posedge clk) begin
		if (ex.accept) begin
			byte_q <= s_tdata;
			eot_q  <= s_tlast;
		end
	end

	// string and escape tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			str_q <= 1'b0;
			bsl_q <= 1'b0;
		end else if (ex.done && eot_q) begin
			str_q <= 1'b0;
			bsl_q <= 1'b0;
		end else if (ex.accept && pretty_q) begin
			str_q <= str_nx;
			bsl_q <= (s_tdata == CH_BSL);
		end
	end

	// nesting depth, saturating at both ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (ex.done && eot_q) begin
			depth_q <= '0;
		end else if (ex.act) begin
			case (ctrl.dep)
				DP_INC: begin
					if (depth_q < DW'(MAX_DEPTH)) begin
						depth_q <= depth_q + DW'(1);
					end
				end
				DP_DEC: begin
					if (depth_q != '0) begin
						depth_q <= depth_q - DW'(1);
					end
				end
				default: begin
					depth_q <= depth_q;
				end
			endcase
		end
	end

	// indent space counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ex.act) begin
			case (ctrl.cnt)
				CN_LOAD: cnt_q <= CW'(depth_q * SPACES_PER_LEVEL);
				CN_DEC:  cnt_q <= cnt_q - CW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	// emitted item selection
	always_comb begin
		ld = ex.act && (ctrl.emit != EM_NONE);
		case (ctrl.emit)
			EM_NL:   emit_byte = CH_NL;
			EM_SP:   emit_byte = CH_SP;
			default: emit_byte = byte_q;
		endcase
		case (ctrl.lst)
			LS_YES:    emit_last = 1'b1;
			LS_DEPTH0: emit_last = (depth_q == '0);
			LS_CNT1:   emit_last = (cnt_q == CW'(1));
			default:   emit_last = 1'b0;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_byte_q <= emit_byte;
			out_last_q <= emit_last;
		end
	end

	always_comb begin
		st.cnt_zero = (cnt_q == '0);
		st.cnt_one  = (cnt_q == CW'(1));
		st.out_free = !out_valid_q || m_tready;
		m_tvalid    = out_valid_q;
		m_tdata     = out_byte_q;
		m_tlast     = out_last_q;
	end

`ifndef NO_ASSERTIONS
	// depth stays within its configured range
	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= DW'(MAX_DEPTH))
		else $error("nesting depth beyond maximum");

	// a waiting item is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ld && out_valid_q) |-> m_tready)
		else $error("output item overwritten");

	// the indent counter never wraps below zero
	a_cnt_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(ex.act && ctrl.cnt == CN_DEC) |-> (cnt_q != '0))
		else $error("indent counter underflow");

	// end of text leaves the scan state cleared
	a_eot_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(ex.done && eot_q) |=> (depth_q == '0 && !str_q && !bsl_q))
		else $error("state not cleared at end of text");
`endif

endmodule

`default_nettype wire

### rtl/json_pretty_print_stream.sv
// Streaming JSON pretty printer. One byte of JSON text is taken per input item
// (end_of_text on tlast) and the reformatted text leaves one byte per output item,
// tlast marking the last byte caused by an input byte. A small microcode program,
// picked by the class of the byte, steps the datapath one control word per cycle
// unless the output stalls, and the output register takes at most one byte per cycle.
// A plain byte passes, a dropped one sends nothing, a colon adds a space, a comma or
// opening bracket adds a newline and n = depth * SPACES_PER_LEVEL spaces after it and
// a closing one puts them before it. The next byte is accepted once the previous one
// has handed its last result to the output register. pretty_enable (cfg_we/cfg_wdata,
// reset 1) must be written by the user only while idle; the block does not enforce it.
`default_nettype none

module json_pretty_print_stream #(
	parameter int MAX_DEPTH        = 15,
	parameter int SPACES_PER_LEVEL = 2
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_tvalid,
	output logic       s_tready,
	input  wire [7:0]  s_tdata,   // [7:0] in_byte
	input  wire        s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  wire        m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,   // run_last
	input  wire        cfg_we,
	input  wire        cfg_wdata  // pretty_enable
);
	import jpp_pkg::*;

	uaddr_t entry;
	uaddr_t step;
	ctrl_t  ctrl;
	exec_t  ex;
	stat_t  st;

	// program store
	jpp_ucode_rom u_rom (
		.addr (step),
		.word (ctrl)
	);

	// step counter
	jpp_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.entry    (entry),
		.ctrl     (ctrl),
		.st       (st),
		.step     (step),
		.ex       (ex)
	);

	// datapath
	jpp_dpath #(
		.MAX_DEPTH        (MAX_DEPTH),
		.SPACES_PER_LEVEL (SPACES_PER_LEVEL)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.ctrl      (ctrl),
		.ex        (ex),
		.entry     (entry),
		.st        (st),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

`default_nettype wire
